@@ sv/tpad_pkg.sv @@
// ----------------------------------------------------------------------------
// tpad_pkg
// Shared types, constants and the firing-delay ladder of the phase-angle dimmer.
// ----------------------------------------------------------------------------
package tpad_pkg;

  localparam int unsigned PowerW  = 7;
  localparam int unsigned DelayW  = 14;
  localparam int unsigned PulseW  = 8;
  localparam int unsigned LadderN = 20;
  localparam int unsigned StepW   = 5;

  localparam logic [PulseW-1:0] PulseTicks = 8'd20;
  localparam logic [PowerW-1:0] FullPower  = 7'd100;

  // ticks of delay per 5 percent step, lowest power first
  localparam logic [DelayW-1:0] DelayLadder [LadderN] = '{
    14'd8203, 14'd7688, 14'd7334, 14'd7030, 14'd6750,
    14'd6487, 14'd6232, 14'd5984, 14'd5738, 14'd5493,
    14'd5245, 14'd4993, 14'd4734, 14'd4464, 14'd4179,
    14'd3874, 14'd3538, 14'd3157, 14'd2696, 14'd2060
  };

  typedef enum logic [2:0] {
    PhIdle  = 3'b001,
    PhDelay = 3'b010,
    PhPulse = 3'b100
  } phase_e;

  typedef struct packed {
    logic triac_gate;
    logic indicator_led;
  } tick_out_t;

  // power / 5 for power < 100 as (power * 205) >> 10, exact over that range
  function automatic logic [DelayW-1:0] target_delay(input logic [PowerW-1:0] power);
    logic [PowerW+7:0] prod;
    logic [StepW-1:0]  step;
    prod = {8'd0, power} * 15'd205;
    step = prod[StepW+9:10];
    if (power >= FullPower) begin
      return '0;
    end
    if (step > StepW'(LadderN - 1)) begin
      step = StepW'(LadderN - 1);
    end
    return DelayLadder[step];
  endfunction

endpackage

@@ sv/tpad_core.sv @@
// ----------------------------------------------------------------------------
// tpad_core
// Per-tick phase sequencer: delay counter, pulse counter and gate/LED decode.
// ----------------------------------------------------------------------------
module tpad_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  logic                          zero_cross_i,
  input  logic [tpad_pkg::DelayW-1:0]   target_i,
  output tpad_pkg::tick_out_t           res_o
);

  tpad_pkg::phase_e               phase_q, phase_d;
  logic [tpad_pkg::DelayW-1:0]    delay_q, delay_d;
  logic [tpad_pkg::PulseW-1:0]    pulse_q, pulse_d;

  always_comb begin
    phase_d = phase_q;
    delay_d = delay_q;
    pulse_d = pulse_q;
    res_o   = '0;

    unique case (phase_q) inside
      tpad_pkg::PhDelay,
      tpad_pkg::PhPulse: phase_d = phase_q;
      default:           phase_d = tpad_pkg::PhIdle;
    endcase

    // zero-cross restarts the delay unless a pulse is running
    if (zero_cross_i && phase_d != tpad_pkg::PhPulse) begin
      phase_d = tpad_pkg::PhDelay;
      delay_d = '0;
    end

    if (phase_d == tpad_pkg::PhDelay) begin
      if (delay_d >= target_i) begin
        phase_d = tpad_pkg::PhPulse;
        pulse_d = '0;
      end else begin
        delay_d = delay_d + 1'b1;
      end
    end

    if (phase_d == tpad_pkg::PhDelay) begin
      res_o.indicator_led = 1'b1;
    end else if (phase_d == tpad_pkg::PhPulse) begin
      res_o.triac_gate    = 1'b1;
      res_o.indicator_led = 1'b1;
      pulse_d = pulse_d + 1'b1;
      if (pulse_d >= tpad_pkg::PulseTicks) begin
        phase_d = tpad_pkg::PhIdle;
        pulse_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= tpad_pkg::PhIdle;
      delay_q <= '0;
      pulse_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      pulse_q <= pulse_d;
    end
  end

endmodule

@@ sv/triac_phase_angle_dimmer.sv @@
// ----------------------------------------------------------------------------
// triac_phase_angle_dimmer
// Phase-angle triac dimmer stepped once per 1 us tick request.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one request per tick; tdata[0] is the zero-cross flag.
//   m_axis returns one result per request; tdata[0] triac gate,
//   tdata[1] indicator LED.
//   cfg_valid_i/cfg_data_i write the power percent (0..100, above 100 acts
//   as 100); the port is always ready. Write it only while the block is idle.
//   A request accepted at an edge shows its result in the output register
//   after that edge. Throughput is one request per cycle while the receiver
//   keeps up; the tick sequencer and the output register both advance in
//   the same cycle, on the single pass through the delay compare.
//   When the receiver stalls, the output register holds its result and the
//   input side takes one more request only once that result is taken.
//   Reset clears the sequencer to idle, the counters to zero, the power to
//   zero (longest delay, 8203 ticks) and empties the output register.
// ----------------------------------------------------------------------------
module triac_phase_angle_dimmer (
  input  logic       clk_i,
  input  logic       rst_ni,
  // config write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_data_i,
  // tick requests
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] zero_cross, [7:1] zero
  // tick results
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [0] triac_gate, [1] indicator_led, [7:2] zero
);

  logic [tpad_pkg::PowerW-1:0] power_q;
  logic [tpad_pkg::DelayW-1:0] target;
  tpad_pkg::tick_out_t         res, res_q;
  logic                        out_valid_q;
  logic                        step;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign step          = s_axis_tvalid && s_axis_tready;
  assign target        = tpad_pkg::target_delay(power_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= '0;
    end else if (cfg_valid_i) begin
      power_q <= cfg_data_i;
    end
  end

  tpad_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .zero_cross_i (s_axis_tdata[0]),
    .target_i     (target),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, res_q.indicator_led, res_q.triac_gate};

endmodule

@@ sim/tb_triac_phase_angle_dimmer.sv @@
// ----------------------------------------------------------------------------
// tb_triac_phase_angle_dimmer
// Self-checking bench for the phase-angle dimmer. Zero-cross ticks are queued
// by the stimulus process and fed by a stream driver with random gaps. A
// monitor steps a local dimmer model on each accepted request and checks the
// gate and LED bits of each result in order. Power is rewritten only once
// all results have been returned.
// ----------------------------------------------------------------------------
module tb_triac_phase_angle_dimmer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 3_000_000;
  localparam int IdlePct    = 19;
  localparam int RandTicks  = 1250;
  // longest delay run per burst; real ladder delays are far longer
  localparam int RunCap     = 40;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_valid_i   = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_data_i    = '0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = '0;   // [0] zero_cross, [7:1] zero
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;         // [0] triac_gate, [1] indicator_led, [7:2] zero

  triac_phase_angle_dimmer dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // model state, owned by the monitor
  logic [tpad_pkg::PowerW-1:0] power_pct  = '0;
  tpad_pkg::phase_e            dim_phase  = tpad_pkg::PhIdle;
  logic [tpad_pkg::DelayW-1:0] tick_count = '0;
  logic [tpad_pkg::PulseW-1:0] gate_ticks = '0;
  int                          n_errors   = 0;

  logic                  pending_zc_q [$];
  tpad_pkg::tick_out_t   owed_outputs_q [$];

  // stimulus side
  logic [tpad_pkg::PowerW-1:0] stim_power = '0;
  logic                        steady     = 1'b0;
  int                          n_queued   = 0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic int fire_delay(input logic [tpad_pkg::PowerW-1:0] pct);
    if (pct >= tpad_pkg::FullPower) begin
      return 0;
    end
    return int'(tpad_pkg::DelayLadder[pct / 5]);
  endfunction

  // one tick of the dimmer: zero-cross first, then the delay compare,
  // then the outputs from the resulting phase
  function automatic tpad_pkg::tick_out_t step_dimmer(input logic zc);
    tpad_pkg::tick_out_t o;
    o = '0;
    if (zc && dim_phase != tpad_pkg::PhPulse) begin
      dim_phase  = tpad_pkg::PhDelay;
      tick_count = '0;
    end
    if (dim_phase == tpad_pkg::PhDelay) begin
      if (tick_count >= fire_delay(power_pct)) begin
        dim_phase  = tpad_pkg::PhPulse;
        gate_ticks = '0;
      end else begin
        tick_count = tick_count + 1'b1;
      end
    end
    if (dim_phase == tpad_pkg::PhDelay) begin
      o.indicator_led = 1'b1;
    end else if (dim_phase == tpad_pkg::PhPulse) begin
      o.triac_gate    = 1'b1;
      o.indicator_led = 1'b1;
      gate_ticks      = gate_ticks + 1'b1;
      if (gate_ticks >= tpad_pkg::PulseTicks) begin
        dim_phase  = tpad_pkg::PhIdle;
        gate_ticks = '0;
      end
    end
    return o;
  endfunction

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_zc_q.size() != 0 && (steady || $urandom_range(99, 0) >= IdlePct)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pending_zc_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor: power capture, prediction and result check
  always @(posedge clk_i) begin
    tpad_pkg::tick_out_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        power_pct = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        owed_outputs_q.push_back(step_dimmer(s_axis_tdata[0]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (owed_outputs_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual tdata %b",
                   $realtime, m_axis_tdata);
        end else begin
          want = owed_outputs_q.pop_front();
          if (m_axis_tdata[0] !== want.triac_gate) begin
            n_errors++;
            $display("%0t: triac_gate expected %b actual %b",
                     $realtime, want.triac_gate, m_axis_tdata[0]);
          end
          if (m_axis_tdata[1] !== want.indicator_led) begin
            n_errors++;
            $display("%0t: indicator_led expected %b actual %b",
                     $realtime, want.indicator_led, m_axis_tdata[1]);
          end
          if (m_axis_tdata[7:2] !== 6'd0) begin
            n_errors++;
            $display("%0t: pad bits expected %b actual %b",
                     $realtime, 6'd0, m_axis_tdata[7:2]);
          end
        end
      end
      m_axis_tready <= steady || ($urandom_range(99, 0) >= IdlePct);
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  task automatic push_tick(input logic zc);
    pending_zc_q.push_back(zc);
    n_queued++;
  endtask

  task automatic push_run(input int n);
    repeat (n) push_tick(1'b0);
  endtask

  // hold off until every queued request has come back as a result
  task automatic drain_outputs();
    do @(posedge clk_i);
    while (pending_zc_q.size() != 0 || s_axis_tvalid || owed_outputs_q.size() != 0);
  endtask

  task automatic write_power(input logic [tpad_pkg::PowerW-1:0] pct);
    drain_outputs();
    cfg_data_i  <= pct;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    stim_power = pct;
  endtask

  function automatic logic [tpad_pkg::PowerW-1:0] pick_power();
    case ($urandom_range(9, 0)) inside
      [0:3]:   return tpad_pkg::PowerW'($urandom_range(127, 100));
      [4:6]:   return tpad_pkg::PowerW'($urandom_range(99, 80));
      default: return tpad_pkg::PowerW'($urandom_range(79, 0));
    endcase
  endfunction

  // delay run for a power, held short so a burst stays a few dozen ticks
  function automatic int run_len(input logic [tpad_pkg::PowerW-1:0] pct);
    int lim;
    lim = fire_delay(pct);
    if (lim > RunCap) begin
      lim = RunCap;
    end
    return lim;
  endfunction

  // noise, then one zero-cross and a run shaped around the firing point
  task automatic run_burst();
    int lim;
    logic [tpad_pkg::PowerW-1:0] alt;
    lim = run_len(stim_power);
    repeat ($urandom_range(5, 0)) push_tick(1'($urandom_range(1, 0)));
    push_tick(1'b1);
    case ($urandom_range(3, 0))
      0: push_run(lim + tpad_pkg::PulseTicks + $urandom_range(8, 0));
      // cut short: the next zero-cross restarts the delay
      1: push_run($urandom_range(lim, 0));
      // zero-cross lands inside the pulse when the run reaches the firing point
      2: begin
        push_run(lim + $urandom_range(tpad_pkg::PulseTicks - 2, 0));
        push_tick(1'b1);
        push_run(tpad_pkg::PulseTicks + 2);
      end
      // retune mid-delay
      default: begin
        push_run($urandom_range(lim, 0));
        alt = pick_power();
        write_power(alt);
        push_run(run_len(alt) + tpad_pkg::PulseTicks + 2);
      end
    endcase
  endtask

  initial begin
    int phase_no;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: an idle tick, a delay at lowest power, then full power while
    // the counter is already past zero, a zero-cross inside the pulse,
    // and a zero-delay fire above full scale
    write_power(7'd0);
    push_tick(1'b0);
    push_tick(1'b1);
    push_run(2);
    write_power(7'd100);
    push_run(2);
    push_tick(1'b1);
    push_run(17);
    write_power(7'd127);
    push_tick(1'b1);

    n_queued = 0;
    phase_no = 0;
    while (n_queued < RandTicks) begin
      steady = (phase_no == 2);
      case (phase_no)
        0:       write_power(7'd0);
        1:       write_power(7'd99);
        default: write_power(pick_power());
      endcase
      repeat ($urandom_range(4, 2)) run_burst();
      phase_no++;
    end
    steady = 1'b0;

    drain_outputs();
    repeat (8) @(posedge clk_i);
    if (owed_outputs_q.size() != 0) begin
      n_errors++;
      $display("%0t: results missing, expected %0d more, actual 0",
               $realtime, owed_outputs_q.size());
    end
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
